// ===== hdl/cmr_pkg.sv =====
`default_nettype none
package cmr_pkg;

	localparam int HEADER_BYTES    = 12;
	localparam int MAX_CHUNK_BYTES = 512;
	localparam int OFS_NUMBER      = 4;
	localparam int OFS_COUNT       = 6;
	localparam int OFS_ID          = 8;
	localparam logic [31:0] MAGIC_WORD = 32'hDEAD_BEEF;

	localparam int POS_W     = 16;
	localparam int LEN_W     = 16;
	localparam int ID_W      = 32;
	localparam int HDR_IDX_W = $clog2(HEADER_BYTES - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_MAGIC   = 3'd1,
		ERR_ID      = 3'd2,
		ERR_SEQ     = 3'd3,
		ERR_LONG    = 3'd4,
		ERR_SHORT   = 3'd5,
		ERR_TIMEOUT = 3'd6
	} err_t;

	typedef struct packed {
		logic             timeout;
		logic [7:0]       rx_byte;
		logic [LEN_W-1:0] chunk_bytes;
		logic             chunk_end;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       payload_byte;
		logic             message_last;
		logic [LEN_W-1:0] message_length;
		err_t             fault_code;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/chunked_message_reassembler_top.sv =====
// Chunked message reassembler.
// Slave stream: one beat per chunk byte or timeout event. s_tuser is the mode
// (0 byte, 1 timeout), s_tlast marks the final byte of a chunk, s_tdata holds
// the byte and the chunk length. Each chunk opens with a 12-byte header.
// Master stream: at most one beat per input beat. m_tuser is the kind
// (payload byte, message end without byte, error), m_tlast completes a
// message, m_tdata holds the byte, the message length and the fault code.
// Configuration: cfg_valid/cfg_data write the message capacity in bytes; the
// channel is always ready. The user must write it only while the block is
// idle; the block does not enforce it. Throughput is one beat per cycle while
// the receiver does not stall: the header checks, the id advance and the
// capacity compare are combinational in the back-end update. A beat is stored
// in the queue, then its result in the output register; earlier queued beats
// delay it. A two-entry queue parts the input from the back end; when the
// receiver stalls, the output register holds, the queue fills and s_tready
// drops. Reset clears all message state, sets the capacity to 65535 and
// empties the queue and the output register; s_tready is then high.
`default_nettype none
module chunked_message_reassembler_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [cmr_pkg::S_DATA_W-1:0] s_tdata,  // rx_byte[7:0], chunk_bytes[23:8]
	input  wire                          s_tlast,
	input  wire                          s_tuser,  // mode[0]
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [cmr_pkg::M_DATA_W-1:0] m_tdata,  // payload_byte[7:0], message_length[23:8],
	                                               // fault_code[26:24], zero[31:27]
	output logic                         m_tlast,
	output logic [1:0]                   m_tuser,  // kind[1:0]
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [cmr_pkg::LEN_W-1:0]    cfg_data
);

	logic [cmr_pkg::LEN_W-1:0] max_q;
	logic                      item_valid;
	cmr_pkg::item_t            item;
	logic                      item_pop;
	cmr_pkg::result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	cmr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	cmr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_bytes  (max_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_valid  (m_tvalid),
		.res        (res),
		.res_ready  (m_tready)
	);

	assign m_tdata = {5'b0, res.fault_code, res.message_length, res.payload_byte};
	assign m_tlast = res.message_last;
	assign m_tuser = res.kind;

	a_full_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input queue full without an output stall");

	a_err_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == cmr_pkg::KIND_ERR)
		|-> (!m_tlast && m_tdata[26:24] != cmr_pkg::ERR_NONE))
		else $error("error beat marked last or without code");

	a_code_only_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != cmr_pkg::KIND_ERR) |-> (m_tdata[26:24] == cmr_pkg::ERR_NONE))
		else $error("fault code on a non-error beat");

endmodule
`default_nettype wire

// ===== hdl/cmr_front.sv =====
`default_nettype none
module cmr_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [cmr_pkg::S_DATA_W-1:0] s_tdata,
	input  wire                          s_tlast,
	input  wire                          s_tuser,
	output logic                         item_valid,
	output cmr_pkg::item_t               item,
	input  wire                          item_pop
);

	cmr_pkg::item_t                ent_q [cmr_pkg::QUEUE_DEPTH];
	logic [cmr_pkg::QPTR_W-1:0]    wr_q;
	logic [cmr_pkg::QPTR_W-1:0]    rd_q;
	logic [cmr_pkg::QPTR_W:0]      cnt_q;
	cmr_pkg::item_t                in_item;
	logic                          push;
	logic                          pop;

	always_comb begin
		in_item.timeout     = s_tuser;
		in_item.rx_byte     = s_tdata[7:0];
		in_item.chunk_bytes = s_tdata[23:8];
		in_item.chunk_end   = s_tlast;
	end

	assign s_tready   = (cnt_q != (cmr_pkg::QPTR_W+1)'(cmr_pkg::QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = ent_q[rd_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == cmr_pkg::QPTR_W'(cmr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == cmr_pkg::QPTR_W'(cmr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cmr_core.sv =====
`default_nettype none
module cmr_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [cmr_pkg::LEN_W-1:0]   max_bytes,
	input  wire                         item_valid,
	input  wire  cmr_pkg::item_t        item,
	output logic                        item_pop,
	output logic                        res_valid,
	output cmr_pkg::result_t            res,
	input  wire                         res_ready
);

	localparam int HDR_LAST = cmr_pkg::HEADER_BYTES - 1;

	logic [7:0]                  hdr_q [HDR_LAST];
	logic [cmr_pkg::POS_W-1:0]   pos_q;
	logic [cmr_pkg::ID_W-1:0]    exp_id_q;
	logic [cmr_pkg::LEN_W-1:0]   prev_q;
	logic [cmr_pkg::LEN_W-1:0]   num_q;
	logic [cmr_pkg::LEN_W-1:0]   tot_q;
	logic [cmr_pkg::LEN_W-1:0]   bsf_q;
	logic                        skip_q;
	logic                        out_vld_q;
	cmr_pkg::result_t            out_q;

	logic [cmr_pkg::POS_W-1:0]   nxt_pos;
	logic [cmr_pkg::ID_W-1:0]    nxt_exp;
	logic [cmr_pkg::LEN_W-1:0]   nxt_prev;
	logic [cmr_pkg::LEN_W-1:0]   nxt_num;
	logic [cmr_pkg::LEN_W-1:0]   nxt_tot;
	logic [cmr_pkg::LEN_W-1:0]   nxt_bsf;
	logic                        nxt_skip;
	logic                        hdr_we;
	logic                        do_fail;
	cmr_pkg::err_t               fail_code;
	logic                        new_vld;
	cmr_pkg::result_t            new_res;

	logic [31:0]                 magic;
	logic [31:0]                 rid;
	logic [15:0]                 hnum;
	logic [15:0]                 htot;
	logic [cmr_pkg::ID_W-1:0]    exp_adv;
	logic [cmr_pkg::LEN_W:0]     cap_sum;
	logic [cmr_pkg::LEN_W:0]     bsf_inc;

	function automatic logic [cmr_pkg::POS_W-1:0] pos_adv(input logic [cmr_pkg::POS_W-1:0] p,
	                                                      input logic e);
		if (e) begin
			return '0;
		end else if (p != '1) begin
			return p + 1'b1;
		end
		return p;
	endfunction

	assign item_pop  = item_valid && (!out_vld_q || res_ready);
	assign res_valid = out_vld_q;
	assign res       = out_q;

	always_comb begin
		magic = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
		rid   = {item.rx_byte, hdr_q[cmr_pkg::OFS_ID+2], hdr_q[cmr_pkg::OFS_ID+1],
		         hdr_q[cmr_pkg::OFS_ID]};
		hnum  = {hdr_q[cmr_pkg::OFS_NUMBER+1], hdr_q[cmr_pkg::OFS_NUMBER]};
		htot  = {hdr_q[cmr_pkg::OFS_COUNT+1], hdr_q[cmr_pkg::OFS_COUNT]};
		if (exp_id_q == '0) begin
			exp_adv = rid;
		end else if (exp_id_q == '1) begin
			exp_adv = cmr_pkg::ID_W'(1);
		end else begin
			exp_adv = exp_id_q + 1'b1;
		end
		cap_sum = {1'b0, bsf_q} + ({1'b0, item.chunk_bytes}
		          - (cmr_pkg::LEN_W+1)'(cmr_pkg::HEADER_BYTES));
		bsf_inc = {1'b0, bsf_q} + 1'b1;
	end

	always_comb begin
		nxt_pos   = pos_q;
		nxt_exp   = exp_id_q;
		nxt_prev  = prev_q;
		nxt_num   = num_q;
		nxt_tot   = tot_q;
		nxt_bsf   = bsf_q;
		nxt_skip  = skip_q;
		hdr_we    = 1'b0;
		do_fail   = 1'b0;
		fail_code = cmr_pkg::ERR_NONE;
		new_vld   = 1'b0;
		new_res   = '0;

		if (item.timeout) begin
			nxt_prev = '0;
			nxt_bsf  = '0;
			nxt_num  = '0;
			nxt_tot  = '0;
			nxt_pos  = '0;
			nxt_skip = 1'b0;
			if (prev_q != '0) begin
				new_vld            = 1'b1;
				new_res.kind       = cmr_pkg::KIND_ERR;
				new_res.fault_code = cmr_pkg::ERR_TIMEOUT;
			end
		end else if (skip_q) begin
			nxt_pos = pos_adv(pos_q, item.chunk_end);
			if (item.chunk_end) begin
				nxt_skip = 1'b0;
			end
		end else if (pos_q < cmr_pkg::POS_W'(HDR_LAST)) begin
			hdr_we = 1'b1;
			if (item.chunk_end) begin
				nxt_prev           = '0;
				nxt_bsf            = '0;
				nxt_num            = '0;
				nxt_tot            = '0;
				nxt_pos            = '0;
				new_vld            = 1'b1;
				new_res.kind       = cmr_pkg::KIND_ERR;
				new_res.fault_code = cmr_pkg::ERR_SHORT;
			end else begin
				nxt_pos = pos_q + 1'b1;
			end
		end else if (pos_q == cmr_pkg::POS_W'(HDR_LAST)) begin
			nxt_num = hnum;
			nxt_tot = htot;
			nxt_exp = exp_adv;
			priority if (magic != cmr_pkg::MAGIC_WORD) begin
				do_fail   = 1'b1;
				fail_code = cmr_pkg::ERR_MAGIC;
			end else if (exp_adv != rid) begin
				nxt_exp   = rid;
				do_fail   = 1'b1;
				fail_code = cmr_pkg::ERR_ID;
			end else if (({1'b0, prev_q} + 1'b1) != {1'b0, hnum}) begin
				do_fail   = 1'b1;
				fail_code = cmr_pkg::ERR_SEQ;
			end else if (item.chunk_bytes < cmr_pkg::LEN_W'(cmr_pkg::HEADER_BYTES)) begin
				do_fail   = 1'b1;
				fail_code = cmr_pkg::ERR_SHORT;
			end else if (item.chunk_bytes > cmr_pkg::LEN_W'(cmr_pkg::MAX_CHUNK_BYTES)
			             || cap_sum > {1'b0, max_bytes}) begin
				do_fail   = 1'b1;
				fail_code = cmr_pkg::ERR_LONG;
			end else begin
				nxt_prev = hnum;
				nxt_pos  = pos_adv(pos_q, item.chunk_end);
				if (item.chunk_end && hnum == htot) begin
					nxt_prev               = '0;
					nxt_bsf                = '0;
					nxt_num                = '0;
					nxt_tot                = '0;
					new_vld                = 1'b1;
					new_res.kind           = cmr_pkg::KIND_END;
					new_res.message_last   = 1'b1;
					new_res.message_length = bsf_q;
				end
			end
		end else begin
			if (bsf_inc > {1'b0, max_bytes}) begin
				do_fail   = 1'b1;
				fail_code = cmr_pkg::ERR_LONG;
			end else begin
				nxt_bsf              = bsf_inc[cmr_pkg::LEN_W-1:0];
				nxt_pos              = pos_adv(pos_q, item.chunk_end);
				new_vld              = 1'b1;
				new_res.kind         = cmr_pkg::KIND_BYTE;
				new_res.payload_byte = item.rx_byte;
				if (item.chunk_end && num_q == tot_q) begin
					nxt_prev               = '0;
					nxt_bsf                = '0;
					nxt_num                = '0;
					nxt_tot                = '0;
					new_res.message_last   = 1'b1;
					new_res.message_length = bsf_inc[cmr_pkg::LEN_W-1:0];
				end
			end
		end

		if (do_fail) begin
			nxt_prev           = '0;
			nxt_bsf            = '0;
			nxt_num            = '0;
			nxt_tot            = '0;
			nxt_skip           = !item.chunk_end;
			nxt_pos            = pos_adv(pos_q, item.chunk_end);
			new_vld            = 1'b1;
			new_res            = '0;
			new_res.kind       = cmr_pkg::KIND_ERR;
			new_res.fault_code = fail_code;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && hdr_we) begin
			hdr_q[pos_q[cmr_pkg::HDR_IDX_W-1:0]] <= item.rx_byte;
		end
		if (item_pop && new_vld) begin
			out_q <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			exp_id_q  <= '0;
			prev_q    <= '0;
			num_q     <= '0;
			tot_q     <= '0;
			bsf_q     <= '0;
			skip_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (item_pop) begin
				pos_q    <= nxt_pos;
				exp_id_q <= nxt_exp;
				prev_q   <= nxt_prev;
				num_q    <= nxt_num;
				tot_q    <= nxt_tot;
				bsf_q    <= nxt_bsf;
				skip_q   <= nxt_skip;
			end
			if (item_pop && new_vld) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;

	localparam int QUIET_LIMIT = 1000;
	localparam int HDR_N       = cmr_pkg::HEADER_BYTES;

	typedef struct {
		cmr_pkg::item_t beat;
		bit             wait_drain;
		bit             calm;
	} stim_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [cmr_pkg::S_DATA_W-1:0] s_tdata   = '0;
	logic                         s_tlast   = 1'b0;
	logic                         s_tuser   = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [cmr_pkg::M_DATA_W-1:0] m_tdata;
	logic                         m_tlast;
	logic [1:0]                   m_tuser;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [cmr_pkg::LEN_W-1:0]    cfg_data  = '0;

	chunked_message_reassembler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reassembly state as the block should hold it
	logic [7:0]                hdr [HDR_N] = '{default: '0};
	logic [cmr_pkg::POS_W-1:0] pos       = '0;
	logic [cmr_pkg::ID_W-1:0]  want_id   = '0;
	logic [15:0]               prev_num  = '0;
	logic [15:0]               cur_num   = '0;
	logic [15:0]               cur_total = '0;
	logic [cmr_pkg::LEN_W-1:0] msg_bytes = '0;
	bit                        skipping  = 1'b0;
	logic [cmr_pkg::LEN_W-1:0] capacity  = 16'hFFFF;

	cmr_pkg::result_t awaited[$];
	stim_t            chunk_stream[$];
	stim_t            nxt;
	cmr_pkg::result_t want;
	logic [31:0]      gen_id = '0;
	bit               gen_calm = 1'b0;
	int               fed = 0;
	int               mismatches = 0;
	int               send_gap = 0;
	int               stall = 0;
	bit               out_calm = 1'b0;
	bit               beat_in = 1'b0;
	bit               beat_out = 1'b0;
	int               quiet = 0;

	function automatic void drop_message();
		prev_num  = '0;
		msg_bytes = '0;
		cur_num   = '0;
		cur_total = '0;
	endfunction

	function automatic void step_pos(input bit last_b);
		if (last_b)
			pos = '0;
		else if (pos != 16'hFFFF)
			pos++;
	endfunction

	function automatic cmr_pkg::result_t abort_msg(input cmr_pkg::err_t code,
	                                               input bit last_b);
		cmr_pkg::result_t r;
		drop_message();
		skipping = !last_b;
		step_pos(last_b);
		r            = '0;
		r.kind       = cmr_pkg::KIND_ERR;
		r.fault_code = code;
		return r;
	endfunction

	task automatic reassemble_beat(input cmr_pkg::item_t it);
		cmr_pkg::result_t r;
		bit               emit;
		bit               last;
		logic [31:0]      magic;
		logic [31:0]      rid;
		int               n;
		emit = 1'b0;
		r    = '0;
		if (it.timeout) begin
			emit = (prev_num != 0);
			drop_message();
			pos      = '0;
			skipping = 1'b0;
			r.kind       = cmr_pkg::KIND_ERR;
			r.fault_code = cmr_pkg::ERR_TIMEOUT;
		end else if (skipping) begin
			if (it.chunk_end)
				skipping = 1'b0;
			step_pos(it.chunk_end);
		end else if (pos < HDR_N - 1) begin
			hdr[pos] = it.rx_byte;
			if (it.chunk_end) begin
				drop_message();
				pos  = '0;
				emit = 1'b1;
				r.kind       = cmr_pkg::KIND_ERR;
				r.fault_code = cmr_pkg::ERR_SHORT;
			end else begin
				pos++;
			end
		end else if (pos == HDR_N - 1) begin
			hdr[HDR_N-1] = it.rx_byte;
			magic     = {hdr[3], hdr[2], hdr[1], hdr[0]};
			rid       = {hdr[cmr_pkg::OFS_ID+3], hdr[cmr_pkg::OFS_ID+2],
			             hdr[cmr_pkg::OFS_ID+1], hdr[cmr_pkg::OFS_ID]};
			cur_num   = {hdr[cmr_pkg::OFS_NUMBER+1], hdr[cmr_pkg::OFS_NUMBER]};
			cur_total = {hdr[cmr_pkg::OFS_COUNT+1], hdr[cmr_pkg::OFS_COUNT]};
			if (want_id == 0) begin
				want_id = rid;
			end else begin
				want_id++;
				if (want_id == 0)
					want_id = 1;
			end
			emit = 1'b1;
			if (magic != cmr_pkg::MAGIC_WORD) begin
				r = abort_msg(cmr_pkg::ERR_MAGIC, it.chunk_end);
			end else if (want_id != rid) begin
				want_id = rid;
				r = abort_msg(cmr_pkg::ERR_ID, it.chunk_end);
			end else if (int'(prev_num) + 1 != int'(cur_num)) begin
				r = abort_msg(cmr_pkg::ERR_SEQ, it.chunk_end);
			end else begin
				prev_num = cur_num;
				if (it.chunk_bytes < HDR_N) begin
					r = abort_msg(cmr_pkg::ERR_SHORT, it.chunk_end);
				end else if (it.chunk_bytes > cmr_pkg::MAX_CHUNK_BYTES ||
				             int'(msg_bytes) + int'(it.chunk_bytes) - HDR_N >
				             int'(capacity)) begin
					r = abort_msg(cmr_pkg::ERR_LONG, it.chunk_end);
				end else begin
					emit = 1'b0;
					step_pos(it.chunk_end);
					if (it.chunk_end && cur_num == cur_total) begin
						emit = 1'b1;
						r.kind           = cmr_pkg::KIND_END;
						r.message_last   = 1'b1;
						r.message_length = msg_bytes;
						drop_message();
					end
				end
			end
		end else begin
			emit = 1'b1;
			n    = int'(msg_bytes) + 1;
			if (n > int'(capacity)) begin
				r = abort_msg(cmr_pkg::ERR_LONG, it.chunk_end);
			end else begin
				msg_bytes = n[15:0];
				last      = it.chunk_end && cur_num == cur_total;
				step_pos(it.chunk_end);
				r.kind         = cmr_pkg::KIND_BYTE;
				r.payload_byte = it.rx_byte;
				if (last) begin
					drop_message();
					r.message_last   = 1'b1;
					r.message_length = n[15:0];
				end
			end
		end
		if (emit)
			awaited.push_back(r);
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// input side: launch beats at the falling edge
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !beat_in)) begin
			if (send_gap != 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (chunk_stream.size() != 0 && chunk_stream[0].wait_drain) begin
				s_tvalid <= 1'b0;
				if (awaited.size() == 0)
					void'(chunk_stream.pop_front());
			end else if (chunk_stream.size() != 0) begin
				nxt = chunk_stream.pop_front();
				s_tdata  <= {nxt.beat.chunk_bytes, nxt.beat.rx_byte};
				s_tlast  <= nxt.beat.chunk_end;
				s_tuser  <= nxt.beat.timeout;
				s_tvalid <= 1'b1;
				send_gap = nxt.calm ? 0 : $urandom_range(0, 9);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		beat_in <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			reassemble_beat({s_tuser, s_tdata[7:0], s_tdata[23:8], s_tlast});
	end

	// output side: stall between result beats
	always @(negedge clk) begin
		if (arst_n) begin
			if (beat_out) begin
				if ($urandom_range(0, 39) == 0)
					out_calm = !out_calm;
				stall = out_calm ? 0 : $urandom_range(0, 9);
			end
			if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		beat_out <= m_tvalid && m_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited.size() == 0) begin
				flag_mismatch("result beat with nothing awaited");
			end else begin
				want = awaited.pop_front();
				if (m_tuser !== want.kind)
					flag_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
				if (m_tdata[7:0] !== want.payload_byte)
					flag_mismatch($sformatf("payload_byte %0h, want %0h",
						m_tdata[7:0], want.payload_byte));
				if (m_tlast !== want.message_last)
					flag_mismatch($sformatf("message_last %0b, want %0b",
						m_tlast, want.message_last));
				if (m_tdata[23:8] !== want.message_length)
					flag_mismatch($sformatf("message_length %0d, want %0d",
						m_tdata[23:8], want.message_length));
				if (m_tdata[26:24] !== want.fault_code)
					flag_mismatch($sformatf("fault_code %0d, want %0d",
						m_tdata[26:24], want.fault_code));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_beat(input bit tmo, input logic [7:0] b, input logic [15:0] cb,
	                         input bit last_b);
		stim_t s;
		s.beat       = {tmo, b, cb, last_b};
		s.wait_drain = 1'b0;
		s.calm       = gen_calm;
		chunk_stream.push_back(s);
		fed++;
	endtask

	task automatic hold_for_results();
		stim_t s;
		s.beat       = '0;
		s.wait_drain = 1'b1;
		s.calm       = 1'b0;
		chunk_stream.push_back(s);
	endtask

	function automatic logic [31:0] good_id();
		logic [31:0] v;
		if (gen_id == 0)
			return $urandom;
		v = gen_id + 1;
		return (v == 0) ? 32'd1 : v;
	endfunction

	// cut > 0: stop after that many bytes without an end and raise a timeout
	task automatic send_chunk(input logic [31:0] magic, input logic [15:0] num,
	                          input logic [15:0] cnt, input logic [31:0] id,
	                          input int plen, input int declared, input int cut);
		logic [7:0] hb [HDR_N];
		int         total;
		{hb[3], hb[2], hb[1], hb[0]} = magic;
		{hb[cmr_pkg::OFS_NUMBER+1], hb[cmr_pkg::OFS_NUMBER]} = num;
		{hb[cmr_pkg::OFS_COUNT+1], hb[cmr_pkg::OFS_COUNT]}   = cnt;
		{hb[cmr_pkg::OFS_ID+3], hb[cmr_pkg::OFS_ID+2], hb[cmr_pkg::OFS_ID+1],
		 hb[cmr_pkg::OFS_ID]} = id;
		total = (cut > 0) ? cut : HDR_N + plen;
		for (int i = 0; i < total; i++)
			push_beat(1'b0, (i < HDR_N) ? hb[i] : 8'($urandom),
			          (i == HDR_N - 1) ? 16'(declared) : 16'($urandom),
			          cut == 0 && i == total - 1);
		if (cut > 0)
			push_beat(1'b1, 8'($urandom), 16'($urandom), 1'($urandom));
		if (total >= HDR_N) begin
			if (gen_id == 0) begin
				gen_id = id;
			end else begin
				gen_id++;
				if (gen_id == 0)
					gen_id = 1;
			end
			if (magic == cmr_pkg::MAGIC_WORD)
				gen_id = id;
		end
	endtask

	task automatic send_stub(input int n);
		for (int i = 0; i < n; i++)
			push_beat(1'b0, 8'($urandom), 16'($urandom), i == n - 1);
	endtask

	task automatic send_message(input int nch);
		int room;
		int plen;
		room = (capacity < 80) ? int'(capacity) : 80;
		for (int c = 1; c <= nch; c++) begin
			plen = $urandom_range(0, (room < 24) ? room : 24);
			room -= plen;
			send_chunk(cmr_pkg::MAGIC_WORD, 16'(c), 16'(nch), good_id(), plen,
			           plen + HDR_N, 0);
		end
	endtask

	task automatic random_traffic(input int n_items);
		int stop;
		int pick;
		int plen;
		stop = fed + n_items;
		while (fed < stop) begin
			gen_calm = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 19);
			plen = $urandom_range(0, 6);
			if (pick < 13) begin
				send_message($urandom_range(1, 4));
			end else begin
				case (pick)
					13: send_chunk(cmr_pkg::MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31)),
					               1, 1, good_id(), plen, plen + HDR_N, 0);
					14: send_chunk(cmr_pkg::MAGIC_WORD, 1, 1,
					               good_id() ^ (32'd1 << $urandom_range(0, 31)),
					               plen, plen + HDR_N, 0);
					15: begin
						case ($urandom_range(0, 2))
							0: send_chunk(cmr_pkg::MAGIC_WORD, 0, 1, good_id(), plen,
							              plen + HDR_N, 0);
							1: send_chunk(cmr_pkg::MAGIC_WORD, 16'($urandom_range(2, 65535)),
							              16'($urandom), good_id(), plen, plen + HDR_N, 0);
							default: send_chunk(cmr_pkg::MAGIC_WORD, 1, 3, good_id(), plen,
							                    plen + HDR_N, 0);
						endcase
					end
					16: begin
						case ($urandom_range(0, 2))
							0: send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), plen,
							              $urandom_range(0, HDR_N - 1), 0);
							1: send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), plen,
							              $urandom_range(cmr_pkg::MAX_CHUNK_BYTES + 1, 65535), 0);
							default: send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), plen,
							                    HDR_N + int'(capacity) + 1, 0);
						endcase
					end
					17: begin
						if (capacity <= 40)
							plen = int'(capacity) + $urandom_range(1, 3);
						else
							plen = $urandom_range(0, 30);
						send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), plen,
						           HDR_N + $urandom_range(0, plen), 0);
					end
					18: begin
						case ($urandom_range(0, 2))
							0: send_stub($urandom_range(1, HDR_N - 1));
							1: push_beat(1'b1, 8'($urandom), 16'($urandom), 1'($urandom));
							default: begin
								send_chunk(cmr_pkg::MAGIC_WORD, 1, 3, good_id(), plen,
								           plen + HDR_N, 0);
								push_beat(1'b1, 8'($urandom), 16'($urandom), 1'($urandom));
							end
						endcase
					end
					default: begin
						if ($urandom_range(0, 3) == 0)
							hold_for_results();
						send_chunk(cmr_pkg::MAGIC_WORD, 1, 2, good_id(), 20, 20 + HDR_N,
						           $urandom_range(1, 30));
					end
				endcase
			end
		end
	endtask

	task automatic drain();
		while (chunk_stream.size() != 0 || s_tvalid || awaited.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		capacity = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] caps [7];
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening at the reset capacity
		gen_calm = 1'b0;
		push_beat(1'b1, 8'hFF, 16'hFFFF, 1'b1);
		send_stub(1);
		send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, 32'hFFFF_FFFF, 2, 2 + HDR_N, 0);
		send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), 0, HDR_N, 0);
		send_chunk(cmr_pkg::MAGIC_WORD, 1, 2, good_id(), 1, 1 + HDR_N, 0);
		push_beat(1'b1, 8'h00, 16'h0000, 1'b0);
		send_chunk(cmr_pkg::MAGIC_WORD, 0, 1, good_id(), 1, 1 + HDR_N, 0);
		send_chunk(32'h0000_0000, 1, 1, good_id(), 0, HDR_N, 0);
		send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, ~good_id(), 0, HDR_N, 0);
		hold_for_results();
		send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), 0, HDR_N - 1, 0);
		send_chunk(cmr_pkg::MAGIC_WORD, 1, 1, good_id(), 1, cmr_pkg::MAX_CHUNK_BYTES + 1, 0);
		send_chunk(cmr_pkg::MAGIC_WORD, 16'hFFFF, 16'hFFFF, good_id(), 1, 65535, 0);

		caps = '{16'hFFFF, 16'd0, 16'd1, 16'd37, 16'($urandom_range(2, 200)), 16'd300,
		         16'hFFFF};
		foreach (caps[k]) begin
			write_capacity(caps[k]);
			random_traffic(230);
		end

		// close with a message sent with no idling
		gen_calm = 1'b1;
		send_message(2);

		drain();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
